// ===== hdl/lhsb_pkg.sv =====
// Shared types, codes and constants for the light hysteresis stepper blind controller.
package lhsb_pkg;

    localparam int unsigned LEVEL_W = 10;
    localparam int unsigned STEPS_W = 16;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned COIL_W  = 4;
    localparam int unsigned CODE_W  = 4;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [LEVEL_W-1:0] OPEN_THRESHOLD_RST  = 10'd600;
    localparam logic [LEVEL_W-1:0] CLOSE_THRESHOLD_RST = 10'd400;
    localparam logic [STEPS_W-1:0] STEP_COUNT_RST      = 16'd3000;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_LIGHT   = 2'd1;
    localparam logic [1:0] OP_COMMAND = 2'd2;

    localparam logic [7:0] CMD_LIGHT  = 8'h6C;
    localparam logic [7:0] CMD_MANUAL = 8'h6D;
    localparam logic [7:0] CMD_OPEN   = 8'h6F;
    localparam logic [7:0] CMD_CLOSE  = 8'h63;

    localparam logic [1:0] REG_OPEN_THRESHOLD  = 2'd0;
    localparam logic [1:0] REG_CLOSE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_STEP_COUNT      = 2'd2;

    typedef enum logic [CODE_W-1:0] {
        ST_NONE           = 4'd0,
        ST_LIGHT_MODE     = 4'd1,
        ST_MANUAL         = 4'd2,
        ST_CMD_OPEN       = 4'd3,
        ST_ALREADY_OPEN   = 4'd4,
        ST_CMD_CLOSE      = 4'd5,
        ST_ALREADY_CLOSED = 4'd6,
        ST_UNKNOWN        = 4'd7,
        ST_LIGHT_OPEN     = 4'd8,
        ST_LIGHT_CLOSE    = 4'd9,
        ST_DONE           = 4'd10,
        ST_BUSY           = 4'd11
    } t_status;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [LEVEL_W-1:0] light_level;
        logic [7:0]         command_byte;
    } t_in_item;

    typedef struct packed {
        logic [COIL_W-1:0] coil_pattern;
        logic [CODE_W-1:0] status_code;
        logic              is_open;
        logic              sensor_mode;
        logic              in_motion;
    } t_out_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] open_threshold;
        logic [LEVEL_W-1:0] close_threshold;
        logic [STEPS_W-1:0] step_count;
    } t_cfg;

    function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] coil;
        unique case (phase)
            3'd0: coil = 4'h8;
            3'd1: coil = 4'hC;
            3'd2: coil = 4'h4;
            3'd3: coil = 4'h6;
            3'd4: coil = 4'h2;
            3'd5: coil = 4'h3;
            3'd6: coil = 4'h1;
            default: coil = 4'h9;
        endcase
        return coil;
    endfunction

endpackage

// ===== hdl/lhsb_core.sv =====
// Blind controller state and the update that produces one result per request.
module lhsb_core
    import lhsb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic               r_pos_open, n_pos_open;
    logic               r_light_mode, n_light_mode;
    logic               r_moving, n_moving;
    logic               r_dir, n_dir;
    logic [STEPS_W-1:0] r_steps_left, n_steps_left;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [COIL_W-1:0]  r_coil, n_coil;
    t_status            n_status;
    t_out_item          r_result;

    logic               start;
    logic               start_open;
    logic [STEPS_W-1:0] steps_dec;

    assign steps_dec = r_steps_left - 1'b1;

    always_comb begin
        n_pos_open   = r_pos_open;
        n_light_mode = r_light_mode;
        n_moving     = r_moving;
        n_dir        = r_dir;
        n_steps_left = r_steps_left;
        n_phase      = r_phase;
        n_coil       = r_coil;
        n_status     = ST_NONE;
        start        = 1'b0;
        start_open   = 1'b0;

        unique case (i_item.opcode)
            OP_TICK: begin
                if (r_moving) begin
                    n_phase      = r_dir ? r_phase + 1'b1 : r_phase - 1'b1;
                    n_coil       = coil_of(n_phase);
                    n_steps_left = steps_dec;
                    if (steps_dec == '0) begin
                        n_moving   = 1'b0;
                        n_pos_open = r_dir;
                        n_status   = ST_DONE;
                    end
                end
            end
            OP_LIGHT: begin
                if (!r_moving && r_light_mode) begin
                    priority if (i_item.light_level > i_cfg.open_threshold && !r_pos_open) begin
                        start      = 1'b1;
                        start_open = 1'b1;
                        n_status   = ST_LIGHT_OPEN;
                    end else if (i_item.light_level < i_cfg.close_threshold
                                 && r_pos_open) begin
                        start    = 1'b1;
                        n_status = ST_LIGHT_CLOSE;
                    end else begin
                        n_status = ST_NONE;
                    end
                end
            end
            OP_COMMAND: begin
                priority if (r_moving) begin
                    n_status = ST_BUSY;
                end else if (i_item.command_byte == CMD_LIGHT) begin
                    n_light_mode = 1'b1;
                    n_status     = ST_LIGHT_MODE;
                end else if (i_item.command_byte == CMD_MANUAL) begin
                    n_light_mode = 1'b0;
                    n_status     = ST_MANUAL;
                end else if (i_item.command_byte == CMD_OPEN) begin
                    if (!r_pos_open) begin
                        start      = 1'b1;
                        start_open = 1'b1;
                        n_status   = ST_CMD_OPEN;
                    end else begin
                        n_status = ST_ALREADY_OPEN;
                    end
                end else if (i_item.command_byte == CMD_CLOSE) begin
                    if (r_pos_open) begin
                        start    = 1'b1;
                        n_status = ST_CMD_CLOSE;
                    end else begin
                        n_status = ST_ALREADY_CLOSED;
                    end
                end else begin
                    n_status = ST_UNKNOWN;
                end
            end
            default: begin
                n_status = ST_NONE;
            end
        endcase

        // A zero travel length completes the travel at once.
        if (start) begin
            if (i_cfg.step_count == '0) begin
                n_pos_open   = start_open;
                n_moving     = 1'b0;
                n_steps_left = '0;
            end else begin
                n_dir        = start_open;
                n_steps_left = i_cfg.step_count;
                n_moving     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_open   <= 1'b0;
            r_light_mode <= 1'b1;
            r_moving     <= 1'b0;
            r_dir        <= 1'b0;
            r_steps_left <= '0;
            r_phase      <= '0;
            r_coil       <= '0;
        end else if (i_en) begin
            r_pos_open   <= n_pos_open;
            r_light_mode <= n_light_mode;
            r_moving     <= n_moving;
            r_dir        <= n_dir;
            r_steps_left <= n_steps_left;
            r_phase      <= n_phase;
            r_coil       <= n_coil;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result.coil_pattern <= n_coil;
            r_result.status_code  <= n_status;
            r_result.is_open      <= n_pos_open;
            r_result.sensor_mode  <= n_light_mode;
            r_result.in_motion    <= n_moving;
        end
    end

    assign o_result = r_result;

endmodule

// ===== hdl/light_hysteresis_stepper_blind.sv =====
// Top level of the light hysteresis stepper blind controller: handshakes, registers, pipeline.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       i_in_valid / o_in_stall  i_in_item  (t_in_item)
//   out       source     o_out_valid / i_out_stall o_out_item (t_out_item)
//   config    sink       APB psel/penable/pready  paddr, pwdata, prdata
//
// An accepted request is held in the input register and feeds the state update, which
// loads the result register when the output is free to take it.
// A new request is accepted every cycle while results are taken.
// Reset is synchronous and active low; it restores the registers and the blind state.
// A stall on the output holds the result and backs up into the input register.
module light_hysteresis_stepper_blind
    import lhsb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    logic      out_free;
    logic      advance;
    logic      in_accept;
    logic      cfg_write;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_threshold  <= OPEN_THRESHOLD_RST;
            r_cfg.close_threshold <= CLOSE_THRESHOLD_RST;
            r_cfg.step_count      <= STEP_COUNT_RST;
        end else if (cfg_write) begin
            if (reg_index == REG_OPEN_THRESHOLD) begin
                r_cfg.open_threshold <= pwdata[LEVEL_W-1:0];
            end
            if (reg_index == REG_CLOSE_THRESHOLD) begin
                r_cfg.close_threshold <= pwdata[LEVEL_W-1:0];
            end
            if (reg_index == REG_STEP_COUNT) begin
                r_cfg.step_count <= pwdata[STEPS_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == REG_OPEN_THRESHOLD) begin
            prdata = {{(DATA_W-LEVEL_W){1'b0}}, r_cfg.open_threshold};
        end else if (reg_index == REG_CLOSE_THRESHOLD) begin
            prdata = {{(DATA_W-LEVEL_W){1'b0}}, r_cfg.close_threshold};
        end else if (reg_index == REG_STEP_COUNT) begin
            prdata = {{(DATA_W-STEPS_W){1'b0}}, r_cfg.step_count};
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    lhsb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (o_out_item)
    );

    assign o_out_valid = r_out_valid;

endmodule

// ===== sim/tb_light_hysteresis_stepper_blind.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the light hysteresis stepper blind controller.
module tb_light_hysteresis_stepper_blind;
    import lhsb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT   = 5000;
    localparam int unsigned RANDOM_PER_PHASE = 65;
    localparam int unsigned PRINT_CAP        = 40;
    localparam logic [1:0]  OP_UNUSED        = 2'd3;
    localparam logic [31:0] HALF_STEP        = 32'h9132_64C8;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_item = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_item;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    light_hysteresis_stepper_blind dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted blind state and register copies.
    t_cfg               cfg;
    logic               pos_open = 1'b0;
    logic               light_mode = 1'b1;
    logic               moving = 1'b0;
    logic               dir_open = 1'b0;
    logic [STEPS_W-1:0] steps_left = '0;
    logic [PHASE_W-1:0] phase = '0;
    logic [COIL_W-1:0]  coil = '0;

    t_in_item  pending_reqs[$];
    t_out_item expected_results[$];
    t_in_item  cur_req;
    bit        presenting = 1'b0;
    bit        in_taken = 1'b0;
    bit        steady_sender = 1'b0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        stall_mode = 0;
    int        stall_run = 0;
    logic [7:0] stall_pat = 8'h5A;

    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned requests_taken = 0;
    int unsigned results_checked = 0;
    int unsigned travels_done = 0;
    int unsigned busy_rejects = 0;
    int unsigned reg_writes = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic start_travel(input logic opening);
        if (cfg.step_count == '0) begin
            pos_open   = opening;
            moving     = 1'b0;
            steps_left = '0;
        end else begin
            dir_open   = opening;
            steps_left = cfg.step_count;
            moving     = 1'b1;
        end
    endtask

    task automatic blind_predict(input t_in_item req, output t_out_item res);
        t_status st;
        st = ST_NONE;
        case (req.opcode)
            OP_TICK: begin
                if (moving) begin
                    phase      = dir_open ? phase + 3'd1 : phase - 3'd1;
                    coil       = HALF_STEP[phase*4 +: 4];
                    steps_left = steps_left - 16'd1;
                    if (steps_left == '0) begin
                        moving   = 1'b0;
                        pos_open = dir_open;
                        st       = ST_DONE;
                        travels_done++;
                    end
                end
            end
            OP_LIGHT: begin
                if (!moving && light_mode) begin
                    if (req.light_level > cfg.open_threshold && !pos_open) begin
                        start_travel(1'b1);
                        st = ST_LIGHT_OPEN;
                    end else if (req.light_level < cfg.close_threshold && pos_open) begin
                        start_travel(1'b0);
                        st = ST_LIGHT_CLOSE;
                    end
                end
            end
            OP_COMMAND: begin
                if (moving) begin
                    st = ST_BUSY;
                    busy_rejects++;
                end else if (req.command_byte == CMD_LIGHT) begin
                    light_mode = 1'b1;
                    st = ST_LIGHT_MODE;
                end else if (req.command_byte == CMD_MANUAL) begin
                    light_mode = 1'b0;
                    st = ST_MANUAL;
                end else if (req.command_byte == CMD_OPEN) begin
                    if (!pos_open) begin
                        start_travel(1'b1);
                        st = ST_CMD_OPEN;
                    end else begin
                        st = ST_ALREADY_OPEN;
                    end
                end else if (req.command_byte == CMD_CLOSE) begin
                    if (pos_open) begin
                        start_travel(1'b0);
                        st = ST_CMD_CLOSE;
                    end else begin
                        st = ST_ALREADY_CLOSED;
                    end
                end else begin
                    st = ST_UNKNOWN;
                end
            end
            default: ;
        endcase
        res.coil_pattern = coil;
        res.status_code  = st;
        res.is_open      = pos_open;
        res.sensor_mode  = light_mode;
        res.in_motion    = moving;
    endtask

    function automatic t_in_item tick_req();
        t_in_item r;
        r.opcode       = OP_TICK;
        r.light_level  = 10'($urandom_range(0, 1023));
        r.command_byte = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic t_in_item light_req(input logic [LEVEL_W-1:0] lvl);
        t_in_item r;
        r              = tick_req();
        r.opcode       = OP_LIGHT;
        r.light_level  = lvl;
        return r;
    endfunction

    function automatic t_in_item cmd_req(input logic [7:0] byte_val);
        t_in_item r;
        r              = tick_req();
        r.opcode       = OP_COMMAND;
        r.command_byte = byte_val;
        return r;
    endfunction

    function automatic t_in_item random_req();
        t_in_item    r;
        int unsigned pick;
        r    = tick_req();
        pick = $urandom_range(0, 99);
        if (pick >= 45 && pick < 65) begin
            r.opcode = OP_LIGHT;
            case ($urandom_range(0, 3))
                0: r.light_level = cfg.open_threshold + 10'($urandom_range(0, 2));
                1: r.light_level = cfg.close_threshold - 10'($urandom_range(0, 2));
                default: ;
            endcase
        end else if (pick >= 65 && pick < 93) begin
            r.opcode = OP_COMMAND;
            case ($urandom_range(0, 5))
                0: r.command_byte = CMD_OPEN;
                1: r.command_byte = CMD_CLOSE;
                2: r.command_byte = CMD_LIGHT;
                3: r.command_byte = CMD_MANUAL;
                4: r.command_byte = pos_open ? CMD_CLOSE : CMD_OPEN;
                default: ;
            endcase
        end else if (pick >= 93) begin
            r.opcode = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic push_ticks(input int unsigned n);
        repeat (n) pending_reqs.push_back(tick_req());
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || presenting || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] want;
        drain();
        want = '0;
        case (idx)
            REG_OPEN_THRESHOLD: begin
                cfg.open_threshold = value[LEVEL_W-1:0];
                want = DATA_W'(cfg.open_threshold);
            end
            REG_CLOSE_THRESHOLD: begin
                cfg.close_threshold = value[LEVEL_W-1:0];
                want = DATA_W'(cfg.close_threshold);
            end
            default: begin
                cfg.step_count = value[STEPS_W-1:0];
                want = DATA_W'(cfg.step_count);
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata != want) report_mismatch("register readback", prdata, want);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
    endtask

    always @(negedge i_clk) begin : driver
        if (in_taken) begin
            in_taken   = 1'b0;
            presenting = 1'b0;
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = steady_sender ? 0 : $urandom_range(0, 10);
            end
        end
        if (!presenting) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                cur_req    = pending_reqs.pop_front();
                presenting = 1'b1;
            end
        end
        i_in_valid <= presenting;
        if (presenting) i_in_item <= cur_req;
    end

    always @(negedge i_clk) begin : receiver
        logic hold;
        case (stall_mode)
            0: hold = 1'b0;
            1: hold = ($urandom_range(0, 2) == 0);
            2: begin
                hold      = stall_pat[0];
                stall_pat = {stall_pat[0], stall_pat[7:1]};
            end
            default: begin
                if (stall_run > 0) begin
                    stall_run--;
                    hold = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_run = $urandom_range(1, 15);
                    hold = 1'b1;
                end else begin
                    hold = 1'b0;
                end
            end
        endcase
        i_out_stall <= hold;
    end

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            idle_cycles++;
            if (i_in_valid && !o_in_stall) begin
                blind_predict(i_in_item, want);
                expected_results.push_back(want);
                in_taken = 1'b1;
                requests_taken++;
                idle_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                idle_cycles = 0;
                got = o_out_item;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request", 32'(got), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.coil_pattern != want.coil_pattern)
                        report_mismatch("coil_pattern", 32'(got.coil_pattern),
                                        32'(want.coil_pattern));
                    if (got.status_code != want.status_code)
                        report_mismatch("status_code", 32'(got.status_code),
                                        32'(want.status_code));
                    if (got.is_open != want.is_open)
                        report_mismatch("is_open", 32'(got.is_open), 32'(want.is_open));
                    if (got.sensor_mode != want.sensor_mode)
                        report_mismatch("sensor_mode", 32'(got.sensor_mode),
                                        32'(want.sensor_mode));
                    if (got.in_motion != want.in_motion)
                        report_mismatch("in_motion", 32'(got.in_motion),
                                        32'(want.in_motion));
                    results_checked++;
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_light_hysteresis_stepper_blind failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned o_thr;
        int unsigned c_thr;
        cfg.open_threshold  = OPEN_THRESHOLD_RST;
        cfg.close_threshold = CLOSE_THRESHOLD_RST;
        cfg.step_count      = STEP_COUNT_RST;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: idle cases and mode changes, then one short travel after a step count write.
        pending_reqs.push_back(tick_req());
        pending_reqs.push_back(light_req(10'd600));
        pending_reqs.push_back(light_req(10'd0));
        pending_reqs.push_back(cmd_req(8'h00));
        pending_reqs.push_back(cmd_req(8'hFF));
        cur_req        = tick_req();
        cur_req.opcode = OP_UNUSED;
        pending_reqs.push_back(cur_req);
        pending_reqs.push_back(cmd_req(CMD_CLOSE));
        pending_reqs.push_back(cmd_req(CMD_MANUAL));
        pending_reqs.push_back(light_req(10'd1023));
        pending_reqs.push_back(cmd_req(CMD_LIGHT));
        cfg_write(REG_STEP_COUNT, 32'd24);
        pending_reqs.push_back(light_req(10'd601));
        pending_reqs.push_back(light_req(10'd0));
        pending_reqs.push_back(cmd_req(CMD_OPEN));
        push_ticks(24);
        pending_reqs.push_back(cmd_req(CMD_OPEN));
        pending_reqs.push_back(tick_req());

        // Extreme thresholds and the shortest travels.
        cfg_write(REG_OPEN_THRESHOLD, 32'd1023);
        cfg_write(REG_CLOSE_THRESHOLD, 32'd0);
        cfg_write(REG_STEP_COUNT, 32'd1);
        pending_reqs.push_back(light_req(10'd0));
        pending_reqs.push_back(cmd_req(CMD_CLOSE));
        pending_reqs.push_back(tick_req());
        pending_reqs.push_back(light_req(10'd1023));
        pending_reqs.push_back(cmd_req(CMD_OPEN));
        pending_reqs.push_back(tick_req());
        cfg_write(REG_STEP_COUNT, 32'd0);
        pending_reqs.push_back(cmd_req(CMD_CLOSE));
        pending_reqs.push_back(cmd_req(CMD_OPEN));
        pending_reqs.push_back(tick_req());
        cfg_write(REG_OPEN_THRESHOLD, 32'd0);
        cfg_write(REG_CLOSE_THRESHOLD, 32'd1023);
        pending_reqs.push_back(light_req(10'd1022));
        pending_reqs.push_back(light_req(10'd0));
        pending_reqs.push_back(light_req(10'd1));

        for (int p = 0; p < 6; p++) begin
            o_thr = $urandom_range(100, 1023);
            c_thr = (p == 4) ? $urandom_range(o_thr, 1023) : $urandom_range(0, o_thr);
            cfg_write(REG_OPEN_THRESHOLD, o_thr);
            cfg_write(REG_CLOSE_THRESHOLD, c_thr);
            cfg_write(REG_STEP_COUNT, (p == 3) ? 32'd0 : $urandom_range(1, 12));
            stall_mode    = p % 4;
            stall_pat     = 8'($urandom_range(1, 254));
            steady_sender = (p == 2);
            repeat (RANDOM_PER_PHASE) pending_reqs.push_back(random_req());
        end

        // The start of a travel at the longest step count, with requests rejected on the way.
        cfg_write(REG_STEP_COUNT, 32'd65535);
        stall_mode    = 1;
        steady_sender = 1'b0;
        pending_reqs.push_back(cmd_req(pos_open ? CMD_CLOSE : CMD_OPEN));
        pending_reqs.push_back(cmd_req(CMD_MANUAL));
        pending_reqs.push_back(light_req(10'd512));
        push_ticks(20);
        pending_reqs.push_back(cmd_req(CMD_OPEN));
        drain();
        repeat (8) @(negedge i_clk);

        $display("Run covered %0d requests and %0d checked results across %0d register writes.",
                 requests_taken, results_checked, reg_writes);
        $display("Blind travels completed: %0d; commands rejected while moving: %0d.",
                 travels_done, busy_rejects);
        if (errors == 0) begin
            $display("tb_light_hysteresis_stepper_blind passed");
        end else begin
            $display("tb_light_hysteresis_stepper_blind failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/lhsb_pkg.sv
hdl/lhsb_core.sv
hdl/light_hysteresis_stepper_blind.sv
sim/tb_light_hysteresis_stepper_blind.sv
